/* hw/rtl/timestamp_text_parser_defines.svh */
// assertion macros for the timestamp text parser
`ifndef TIMESTAMP_TEXT_PARSER_DEFINES_SVH
`define TIMESTAMP_TEXT_PARSER_DEFINES_SVH

// property checked on every rising edge, muted while reset is asserted
`define TSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define TSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/tsp_pkg.sv */
// constants and helper function of the timestamp text parser
`timescale 1ns / 1ps

package tsp_pkg;

  // field widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned TWO_W    = 7;
  localparam int unsigned MILLIS_W = 10;

  // position saturates here, bytes beyond are ignored
  localparam logic [POS_W-1:0] POS_SAT = 5'd23;

  // zero-based positions of the last byte of each accepted length
  localparam logic [POS_W-1:0] POS_END_DATE = 5'd9;
  localparam logic [POS_W-1:0] POS_END_TIME = 5'd18;
  localparam logic [POS_W-1:0] POS_END_FRAC = 5'd22;

  // characters
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_T     = 8'h54;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

  // one decimal step: acc * 10 + digit, modulo the year width
  function automatic logic [YEAR_W-1:0] dec_step(input logic [YEAR_W-1:0] acc,
                                                 input logic [3:0] dig);
    dec_step = (acc << 3) + (acc << 1) + {{(YEAR_W-4){1'b0}}, dig};
  endfunction

endpackage

/* hw/rtl/timestamp_text_parser.sv */
// timestamp text parser: byte-serial YYYY-MM-DD[( |T)HH:MM:SS[.mmm]] decoder
// pipeline: an accepted byte is registered in the input register, then processed;
//   the result of a text is registered in the result register when its last byte is processed
// throughput: one byte per cycle, limited only by a result stalled at the output
// reset: async active low, clears position, accumulators, error flag and valids
`timescale 1ns / 1ps

`include "timestamp_text_parser_defines.svh"

module timestamp_text_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tsp_pkg::CH_W-1:0]         ch_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tsp_pkg::YEAR_W-1:0]       year_o,
  output logic [tsp_pkg::TWO_W-1:0]        month_o,
  output logic [tsp_pkg::TWO_W-1:0]        day_o,
  output logic [tsp_pkg::TWO_W-1:0]        hour_o,
  output logic [tsp_pkg::TWO_W-1:0]        minute_o,
  output logic [tsp_pkg::TWO_W-1:0]        second_o,
  output logic [tsp_pkg::MILLIS_W-1:0]     millis_o,
  output logic                             bad_format_o
);

  import tsp_pkg::*;

  // input register
  logic              in_valid_q, in_valid_d;
  logic [CH_W-1:0]   ch_q;
  logic              last_q;

  // parse state
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [YEAR_W-1:0]   year_q, year_d;
  logic [TWO_W-1:0]    month_q, month_d;
  logic [TWO_W-1:0]    day_q, day_d;
  logic [TWO_W-1:0]    hour_q, hour_d;
  logic [TWO_W-1:0]    minute_q, minute_d;
  logic [TWO_W-1:0]    second_q, second_d;
  logic [MILLIS_W-1:0] millis_q, millis_d;
  logic                err_q, err_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [YEAR_W-1:0]   res_year_q;
  logic [TWO_W-1:0]    res_month_q, res_day_q, res_hour_q, res_minute_q, res_second_q;
  logic [MILLIS_W-1:0] res_millis_q;
  logic                res_bad_q;

  // byte decode
  logic                in_fire, proc_fire, emit;
  logic                is_digit, byte_err, len_ok, bad;
  logic [3:0]          dig;
  logic [YEAR_W-1:0]   year_nx;
  logic [TWO_W-1:0]    month_nx, day_nx, hour_nx, minute_nx, second_nx;
  logic [MILLIS_W-1:0] millis_nx;

  // handshake: a stored byte moves on unless it is a last byte facing a full output
  assign proc_fire  = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign emit       = proc_fire && last_q;
  assign in_ready_o = !in_valid_q || proc_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign dig      = ch_q[3:0];

  // per-position check and accumulate
  always_comb begin
    byte_err  = 1'b0;
    year_nx   = year_q;
    month_nx  = month_q;
    day_nx    = day_q;
    hour_nx   = hour_q;
    minute_nx = minute_q;
    second_nx = second_q;
    millis_nx = millis_q;
    case (pos_q) inside
      [5'd0:5'd3]: begin
        byte_err = !is_digit;
        if (is_digit) year_nx = dec_step(year_q, dig);
      end
      5'd4, 5'd7: begin
        byte_err = (ch_q != CH_DASH);
      end
      [5'd5:5'd6]: begin
        byte_err = !is_digit;
        if (is_digit) month_nx = TWO_W'(dec_step({{(YEAR_W-TWO_W){1'b0}}, month_q}, dig));
      end
      [5'd8:5'd9]: begin
        byte_err = !is_digit;
        if (is_digit) day_nx = TWO_W'(dec_step({{(YEAR_W-TWO_W){1'b0}}, day_q}, dig));
      end
      5'd10: begin
        byte_err = (ch_q != CH_T) && (ch_q != CH_SPACE);
      end
      [5'd11:5'd12]: begin
        byte_err = !is_digit;
        if (is_digit) hour_nx = TWO_W'(dec_step({{(YEAR_W-TWO_W){1'b0}}, hour_q}, dig));
      end
      5'd13, 5'd16: begin
        byte_err = (ch_q != CH_COLON);
      end
      [5'd14:5'd15]: begin
        byte_err = !is_digit;
        if (is_digit) minute_nx = TWO_W'(dec_step({{(YEAR_W-TWO_W){1'b0}}, minute_q}, dig));
      end
      [5'd17:5'd18]: begin
        byte_err = !is_digit;
        if (is_digit) second_nx = TWO_W'(dec_step({{(YEAR_W-TWO_W){1'b0}}, second_q}, dig));
      end
      5'd19: begin
        byte_err = (ch_q != CH_DOT);
      end
      [5'd20:5'd22]: begin
        byte_err = !is_digit;
        if (is_digit) begin
          millis_nx = MILLIS_W'(dec_step({{(YEAR_W-MILLIS_W){1'b0}}, millis_q}, dig));
        end
      end
      default: begin
        byte_err = 1'b0;
      end
    endcase
  end

  // length check uses the position of the last byte
  assign len_ok = (pos_q == POS_END_DATE) || (pos_q == POS_END_TIME) || (pos_q >= POS_END_FRAC);
  assign bad    = err_q || byte_err || !len_ok;

  // next state of the parse registers
  always_comb begin
    pos_d    = pos_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    millis_d = millis_q;
    err_d    = err_q;
    if (emit) begin
      pos_d    = '0;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      millis_d = '0;
      err_d    = 1'b0;
    end else if (proc_fire) begin
      pos_d    = (pos_q < POS_SAT) ? pos_q + 5'd1 : pos_q;
      year_d   = year_nx;
      month_d  = month_nx;
      day_d    = day_nx;
      hour_d   = hour_nx;
      minute_d = minute_nx;
      second_d = second_nx;
      millis_d = millis_nx;
      err_d    = err_q || byte_err;
    end
  end

  // valid flags of both stages
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (proc_fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      year_q      <= '0;
      month_q     <= '0;
      day_q       <= '0;
      hour_q      <= '0;
      minute_q    <= '0;
      second_q    <= '0;
      millis_q    <= '0;
      err_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      second_q    <= second_d;
      millis_q    <= millis_d;
      err_q       <= err_d;
    end
  end

  // input byte register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  // result register, fields zeroed on a format error
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_bad_q    <= bad;
      res_year_q   <= bad ? '0 : year_nx;
      res_month_q  <= bad ? '0 : month_nx;
      res_day_q    <= bad ? '0 : day_nx;
      res_hour_q   <= bad ? '0 : hour_nx;
      res_minute_q <= bad ? '0 : minute_nx;
      res_second_q <= bad ? '0 : second_nx;
      res_millis_q <= bad ? '0 : millis_nx;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign year_o       = res_year_q;
  assign month_o      = res_month_q;
  assign day_o        = res_day_q;
  assign hour_o       = res_hour_q;
  assign minute_o     = res_minute_q;
  assign second_o     = res_second_q;
  assign millis_o     = res_millis_q;
  assign bad_format_o = res_bad_q;

  // checks
  `TSP_ASSERT(a_stall_only_on_full_out, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without a blocked result")
  `TSP_ASSERT(a_pos_restart, emit |=> (pos_q == '0 && !err_q), "parse state not cleared after a result")
  `TSP_ASSERT(a_bad_zero_fields, (out_valid_o && bad_format_o) |-> (year_o == '0 && month_o == '0 && day_o == '0 && millis_o == '0), "error result carries field data")
  `TSP_ASSERT(a_pos_range, pos_q <= POS_SAT, "position beyond saturation")

endmodule

/* sim/timestamp_text_parser_test.sv */
// self-checking testbench for the timestamp text parser
`timescale 1ns / 1ps

module timestamp_text_parser_test;

  import tsp_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned RANDOM_BYTES = 380;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef enum int unsigned {FORM_DATE, FORM_TIME, FORM_FRAC, FORM_LONG} form_e;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [TWO_W-1:0]    month;
    logic [TWO_W-1:0]    day;
    logic [TWO_W-1:0]    hour;
    logic [TWO_W-1:0]    minute;
    logic [TWO_W-1:0]    second;
    logic [MILLIS_W-1:0] millis;
    logic                bad_format;
  } stamp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CH_W-1:0]     ch_i;
  logic                last_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [YEAR_W-1:0]   year_o;
  logic [TWO_W-1:0]    month_o;
  logic [TWO_W-1:0]    day_o;
  logic [TWO_W-1:0]    hour_o;
  logic [TWO_W-1:0]    minute_o;
  logic [TWO_W-1:0]    second_o;
  logic [MILLIS_W-1:0] millis_o;
  logic                bad_format_o;

  // decoder state mirrored at the block's widths
  logic [POS_W-1:0]    parse_pos;
  logic [YEAR_W-1:0]   year_acc;
  logic [TWO_W-1:0]    month_acc;
  logic [TWO_W-1:0]    day_acc;
  logic [TWO_W-1:0]    hour_acc;
  logic [TWO_W-1:0]    minute_acc;
  logic [TWO_W-1:0]    second_acc;
  logic [MILLIS_W-1:0] millis_acc;
  logic                text_bad;

  stamp_t              pending_stamps[$];
  logic [CH_W-1:0]     text_q[$];
  int unsigned         bytes_sent;
  int unsigned         idle_pct;
  int unsigned         stall_pct;
  int unsigned         mismatches;
  int unsigned         quiet_cycles;

  timestamp_text_parser DUT (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // decimal accumulate, truncated by the caller to the field width
  function automatic logic [YEAR_W-1:0] digit_step(input logic [YEAR_W-1:0] acc,
                                                   input logic [CH_W-1:0] c);
    return acc * 14'd10 + {6'd0, c - CH_ZERO};
  endfunction

  task automatic clear_parse_state();
    parse_pos  = '0;
    year_acc   = '0;
    month_acc  = '0;
    day_acc    = '0;
    hour_acc   = '0;
    minute_acc = '0;
    second_acc = '0;
    millis_acc = '0;
    text_bad   = 1'b0;
  endtask

  // advance the decoder by one accepted byte, queue a stamp on the last one
  task automatic decode_byte(input logic [CH_W-1:0] c, input logic is_last);
    logic [POS_W-1:0]  p;
    logic [YEAR_W-1:0] step;
    logic              dig_ok;
    logic              want_digit;
    logic              bad;
    logic              len_ok;
    stamp_t            stamp;
    p          = parse_pos;
    dig_ok     = (c >= CH_ZERO) && (c <= CH_NINE);
    step       = '0;
    want_digit = 1'b0;
    bad        = 1'b0;
    if (p <= 3) begin
      want_digit = 1'b1;
      if (dig_ok) year_acc = digit_step(year_acc, c);
    end else if (p == 4 || p == 7) begin
      bad = (c != CH_DASH);
    end else if (p <= 6) begin
      want_digit = 1'b1;
      step = digit_step(month_acc, c);
      if (dig_ok) month_acc = step[TWO_W-1:0];
    end else if (p <= 9) begin
      want_digit = 1'b1;
      step = digit_step(day_acc, c);
      if (dig_ok) day_acc = step[TWO_W-1:0];
    end else if (p == 10) begin
      bad = (c != CH_T) && (c != CH_SPACE);
    end else if (p <= 12) begin
      want_digit = 1'b1;
      step = digit_step(hour_acc, c);
      if (dig_ok) hour_acc = step[TWO_W-1:0];
    end else if (p == 13 || p == 16) begin
      bad = (c != CH_COLON);
    end else if (p <= 15) begin
      want_digit = 1'b1;
      step = digit_step(minute_acc, c);
      if (dig_ok) minute_acc = step[TWO_W-1:0];
    end else if (p <= 18) begin
      want_digit = 1'b1;
      step = digit_step(second_acc, c);
      if (dig_ok) second_acc = step[TWO_W-1:0];
    end else if (p == 19) begin
      bad = (c != CH_DOT);
    end else if (p <= 22) begin
      want_digit = 1'b1;
      step = digit_step(millis_acc, c);
      if (dig_ok) millis_acc = step[MILLIS_W-1:0];
    end
    if (bad || (want_digit && !dig_ok)) text_bad = 1'b1;
    if (parse_pos < POS_SAT) parse_pos = parse_pos + 1'b1;
    if (is_last) begin
      len_ok = (p == POS_END_DATE) || (p == POS_END_TIME) || (p >= POS_END_FRAC);
      stamp  = '0;
      if (text_bad || !len_ok) begin
        stamp.bad_format = 1'b1;
      end else begin
        stamp.year   = year_acc;
        stamp.month  = month_acc;
        stamp.day    = day_acc;
        stamp.hour   = hour_acc;
        stamp.minute = minute_acc;
        stamp.second = second_acc;
        stamp.millis = millis_acc;
      end
      pending_stamps.push_back(stamp);
      clear_parse_state();
    end
  endtask

  // send one byte request, with an optional idle gap in front
  task automatic send_byte(input logic [CH_W-1:0] c, input logic is_last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(c, is_last);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // hold off the sender until every stamp has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_stamps.size() != 0);
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic push_number(input int unsigned value, input int unsigned digits);
    int unsigned     scale;
    logic [CH_W-1:0] c;
    scale = 1;
    repeat (digits - 1) scale *= 10;
    repeat (digits) begin
      c = CH_W'(CH_ZERO + (value / scale) % 10);
      text_q.push_back(c);
      scale /= 10;
    end
  endtask

  // mostly well-formed stamps, some corrupted, cut or extended, some noise
  task automatic make_random_text();
    int unsigned kind;
    int unsigned cut;
    form_e       form;
    kind = $urandom_range(99);
    if (kind >= 92) begin
      repeat ($urandom_range(30, 1)) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    form = form_e'($urandom_range(3));
    push_number($urandom_range(9999), 4);
    text_q.push_back(CH_DASH);
    push_number($urandom_range(99), 2);
    text_q.push_back(CH_DASH);
    push_number($urandom_range(99), 2);
    if (form != FORM_DATE) begin
      text_q.push_back($urandom_range(1) ? CH_T : CH_SPACE);
      push_number($urandom_range(99), 2);
      text_q.push_back(CH_COLON);
      push_number($urandom_range(99), 2);
      text_q.push_back(CH_COLON);
      push_number($urandom_range(99), 2);
    end
    if (form == FORM_FRAC || form == FORM_LONG) begin
      text_q.push_back(CH_DOT);
      push_number($urandom_range(999), 3);
    end
    if (form == FORM_LONG)
      repeat ($urandom_range(12, 1)) text_q.push_back(8'($urandom_range(255)));
    if (kind >= 80) begin
      // wrong length
      if ($urandom_range(1)) begin
        cut = $urandom_range(text_q.size() - 1, 1);
        while (text_q.size() > cut) void'(text_q.pop_back());
      end else begin
        repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(255)));
      end
    end else if (kind >= 65) begin
      // one byte overwritten
      text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
    end
  endtask

  task automatic run_random_texts(input int unsigned n_bytes);
    int unsigned target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      make_random_text();
      send_text();
    end
    wait_drained();
  endtask

  // extremes, both separators, each bad separator, digit edges, lengths
  task automatic test_directed();
    string cases[14];
    cases = '{"0000-00-00", "9999-99-99T99:99:99.999", "2024-02-29 13:45:07",
              "2024-01-0/", "2024-01-0:", "2024/01-01", "2024-01-01t10:00:00",
              "2024-01-01T10-00:00", "2024-01-01T10:00:00,123", "2024-01-01T",
              "2024-01-01T10:00:00.12", "5", "2024-01-01T10:00:00.",
              "1970-01-01 00:00:00.000"};
    idle_pct  = 0;
    stall_pct = 0;
    foreach (cases[i]) begin
      push_string(cases[i]);
      send_text();
    end
    // long text: bytes past the fraction must be ignored, position saturates
    push_string("1999-12-31T23:59:59.000Z+01:00");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    push_string("trailing bytes");
    send_text();
    wait_drained();
  endtask

  task automatic test_full_rate();
    idle_pct  = 0;
    stall_pct = 0;
    run_random_texts(RANDOM_BYTES);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 85;
    stall_pct = 0;
    run_random_texts(RANDOM_BYTES);
  endtask

  task automatic test_receiver_stall();
    idle_pct  = 0;
    stall_pct = 85;
    run_random_texts(RANDOM_BYTES);
  endtask

  task automatic test_both_gaps();
    idle_pct  = 16;
    stall_pct = 16;
    run_random_texts(RANDOM_BYTES);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each returned stamp with the oldest pending one
  always @(posedge clk_i) begin
    stamp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_stamps.size() == 0) begin
        $error("result request with no stamp pending");
        mismatches++;
      end else begin
        want = pending_stamps.pop_front();
        check_field("year", want.year, year_o);
        check_field("month", want.month, month_o);
        check_field("day", want.day, day_o);
        check_field("hour", want.hour, hour_o);
        check_field("minute", want.minute, minute_o);
        check_field("second", want.second, second_o);
        check_field("millis", want.millis, millis_o);
        check_field("bad_format", want.bad_format, bad_format_o);
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[timestamp_text_parser] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    ch_i         = '0;
    last_i       = 1'b0;
    out_ready_i  = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    bytes_sent   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    clear_parse_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stall();
    test_both_gaps();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_stamps.size() == 0) begin
      $display("[timestamp_text_parser] OK");
    end else begin
      $display("[timestamp_text_parser] ERROR");
    end
    $finish;
  end

endmodule
